// ===== hdl/stbs_pkg.sv =====
// Package for the sorted table binary search core.
// Holds field widths, mode codes, engine states and the engine status type.
// No dependencies.
`default_nettype none

package stbs_pkg;

  // Field widths of the beats
  localparam int IndexW = 10;
  localparam int ValueW = 32;
  localparam int HighW  = 11;
  // Search bounds carry two extra bits so that lo can pass hi by one
  localparam int BoundW = IndexW + 2;
  localparam int IndexMax = (2 ** IndexW) - 1;

  localparam int TableDepth = 1024;

  typedef enum logic {
    ModeWrite  = 1'b0,
    ModeSearch = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StSeek,
    StProbe,
    StDone
  } state_e;

  typedef struct packed {
    logic busy;
    logic probing;
  } eng_stat_t;

endpackage

`default_nettype wire

// ===== hdl/stbs_in_if.sv =====
// Input channel of the search core: write and search beats.
// Depends on stbs_pkg for field widths.
`default_nettype none

interface stbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic        [stbs_pkg::IndexW-1:0]   entry_index;
  logic signed [stbs_pkg::ValueW-1:0]   entry_value;
  logic signed [stbs_pkg::ValueW-1:0]   search_key;
  logic        [stbs_pkg::IndexW-1:0]   range_low;
  logic signed [stbs_pkg::HighW-1:0]    range_high;

  modport source (
    output valid, mode, entry_index, entry_value, search_key, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, entry_value, search_key, range_low, range_high,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stbs_out_if.sv =====
// Output channel of the search core: one result beat per search.
// Depends on stbs_pkg for field widths.
`default_nettype none

interface stbs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::IndexW-1:0]   position;

  modport source (
    output valid, found, position,
    input  ready
  );
  modport sink (
    input  valid, found, position,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stbs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stbs_engine.sv =====
// Search engine: takes input beats, writes the table, runs the probe loop
// against the table RAM and offers one result per search.
// Depends on stbs_pkg and stbs_in_if.
`default_nettype none

module stbs_engine #(
  parameter int TableDepth = stbs_pkg::TableDepth
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  stbs_in_if.sink                                   in_i,
  // Table RAM ports
  output logic                                      wr_en_o,
  output logic        [$clog2(TableDepth)-1:0]      wr_addr_o,
  output logic        [stbs_pkg::ValueW-1:0]        wr_data_o,
  output logic                                      rd_en_o,
  output logic        [$clog2(TableDepth)-1:0]      rd_addr_o,
  input  wire logic   [stbs_pkg::ValueW-1:0]        rd_data_i,
  // Result towards the output register
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i,
  output logic                                      res_found_o,
  output logic        [stbs_pkg::IndexW-1:0]        res_position_o,
  output stbs_pkg::eng_stat_t                       stat_o
);

  localparam int AddrW  = $clog2(TableDepth);
  localparam int BoundW = stbs_pkg::BoundW;
  localparam int IndexW = stbs_pkg::IndexW;
  localparam int HiMaxInt = (TableDepth - 1 > stbs_pkg::IndexMax) ?
                            stbs_pkg::IndexMax : TableDepth - 1;
  localparam logic signed [BoundW-1:0] HiMax = BoundW'(HiMaxInt);
  localparam logic signed [BoundW-1:0] BoundOne = BoundW'(1);

  stbs_pkg::state_e state_q, state_d;
  logic signed [stbs_pkg::ValueW-1:0] key_q, key_d;
  logic signed [BoundW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IndexW-1:0] mid_q, mid_d;
  logic found_q, found_d;
  logic [IndexW-1:0] pos_q, pos_d;

  logic signed [BoundW-1:0] hi_in;
  logic signed [BoundW-1:0] sum_seek;
  logic signed [BoundW-1:0] lo_nx, hi_nx, sum_nx;
  logic signed [BoundW-1:0] mid_ext;
  logic signed [stbs_pkg::ValueW-1:0] probe_val;
  logic accept;

  assign accept    = in_i.valid && in_i.ready;
  assign hi_in     = BoundW'(in_i.range_high);
  assign sum_seek  = lo_q + hi_q;
  assign mid_ext   = $signed({2'b00, mid_q});
  assign probe_val = $signed(rd_data_i);

  // Table writes come straight from accepted write beats
  assign wr_addr_o = AddrW'(in_i.entry_index);
  assign wr_data_o = in_i.entry_value;

  // State and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  // Next state, RAM requests and bound updates
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    pos_d       = pos_q;
    in_i.ready  = 1'b0;
    wr_en_o     = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = AddrW'(mid_q);
    res_valid_o = 1'b0;
    lo_nx       = lo_q;
    hi_nx       = hi_q;
    sum_nx      = lo_q + hi_q;

    unique case (state_q)
      stbs_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (accept) begin
          if (in_i.mode == stbs_pkg::ModeSearch) begin
            // Latch key and range, clamp the top of the range to the table
            key_d   = in_i.search_key;
            lo_d    = $signed({2'b00, in_i.range_low});
            hi_d    = (hi_in > HiMax) ? HiMax : hi_in;
            state_d = stbs_pkg::StSeek;
          end else begin
            // Drop writes that fall beyond the table
            wr_en_o = (32'(in_i.entry_index) < 32'(TableDepth));
          end
        end
      end

      stbs_pkg::StSeek: begin
        if (lo_q > hi_q) begin
          found_d = 1'b0;
          pos_d   = '0;
          state_d = stbs_pkg::StDone;
        end else begin
          // Issue the first probe at the midpoint
          mid_d     = sum_seek[IndexW:1];
          rd_en_o   = 1'b1;
          rd_addr_o = AddrW'(mid_d);
          state_d   = stbs_pkg::StProbe;
        end
      end

      stbs_pkg::StProbe: begin
        if (probe_val == key_q) begin
          found_d = 1'b1;
          pos_d   = mid_q;
          state_d = stbs_pkg::StDone;
        end else begin
          // Narrow to the lower or upper half
          if (probe_val > key_q) begin
            hi_nx = mid_ext - BoundOne;
          end else begin
            lo_nx = mid_ext + BoundOne;
          end
          lo_d   = lo_nx;
          hi_d   = hi_nx;
          sum_nx = lo_nx + hi_nx;
          if (lo_nx > hi_nx) begin
            found_d = 1'b0;
            pos_d   = '0;
            state_d = stbs_pkg::StDone;
          end else begin
            // Issue the next probe back to back
            mid_d     = sum_nx[IndexW:1];
            rd_en_o   = 1'b1;
            rd_addr_o = AddrW'(mid_d);
          end
        end
      end

      stbs_pkg::StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = stbs_pkg::StIdle;
        end
      end

      default: begin
        state_d = stbs_pkg::StIdle;
      end
    endcase
  end

  assign res_found_o    = found_q;
  assign res_position_o = pos_q;

  assign stat_o.busy    = (state_q != stbs_pkg::StIdle);
  assign stat_o.probing = (state_q == stbs_pkg::StSeek) || (state_q == stbs_pkg::StProbe);

endmodule

`default_nettype wire

// ===== hdl/sorted_table_binary_search_core.sv =====
// Sorted table binary search core: 32-bit signed table in one RAM, searched by halving.
// Write beats are taken in StIdle and go straight to the RAM. A search is taken in StIdle,
// then passes StSeek (setup), StProbe, one RAM read per cycle through the single read port
// (at most 11 probes for a 1024-entry range), and StDone, which hands over the result when
// the output register can take it; the next beat is taken while the result waits there.
// Reset clears control state only; table contents are undefined until written.
`default_nettype none

module sorted_table_binary_search_core #(
  parameter int TableDepth = stbs_pkg::TableDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stbs_in_if.sink     in_i,
  stbs_out_if.source  out_o
);

  localparam int AddrW = $clog2(TableDepth);

  logic                          wr_en;
  logic [AddrW-1:0]              wr_addr;
  logic [stbs_pkg::ValueW-1:0]   wr_data;
  logic                          rd_en;
  logic [AddrW-1:0]              rd_addr;
  logic [stbs_pkg::ValueW-1:0]   rd_data;
  logic                          res_valid;
  logic                          res_ready;
  logic                          res_found;
  logic [stbs_pkg::IndexW-1:0]   res_position;
  stbs_pkg::eng_stat_t           eng_stat;

  logic                          out_valid_q;
  logic                          out_found_q;
  logic [stbs_pkg::IndexW-1:0]   out_position_q;

  stbs_ram #(
    .Width (stbs_pkg::ValueW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stbs_engine #(
    .TableDepth (TableDepth)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_found_o    (res_found),
    .res_position_o (res_position),
    .stat_o         (eng_stat)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_found_q    <= res_found;
      out_position_q <= res_position;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_position_q;

`ifndef SYNTHESIS
  // A miss always reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.position == '0)
    else $error("miss beat carries a non-zero position");

  // A hit lies inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |-> 32'(out_o.position) < 32'(TableDepth))
    else $error("hit position beyond the table");

  // Table writes never overlap a probe sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !eng_stat.probing)
    else $error("table write during a search");

  // An accepted search beat starts the engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.mode == stbs_pkg::ModeSearch |=> eng_stat.probing)
    else $error("search beat accepted but no probe started");

  // Input beats are only taken while the engine is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !eng_stat.busy)
    else $error("input ready while the engine is busy");
`endif

endmodule

`default_nettype wire
